// ----- rtl/core/irn_pkg.sv -----
package irn_pkg;

    localparam int unsigned NUM_W    = 12;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W   = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [NUM_W-1:0] VALUE_MAX = 12'd3999;

    // ASCII codes of the Roman letters.
    localparam logic [CHAR_W-1:0] CHAR_I    = 8'h49;
    localparam logic [CHAR_W-1:0] CHAR_V    = 8'h56;
    localparam logic [CHAR_W-1:0] CHAR_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_L    = 8'h4C;
    localparam logic [CHAR_W-1:0] CHAR_C    = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_D    = 8'h44;
    localparam logic [CHAR_W-1:0] CHAR_M    = 8'h4D;
    localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;

    // One queued number, as offered by the front part to the back part.
    typedef struct packed {
        logic             valid;
        logic [NUM_W-1:0] value;
    } t_job;

    // Value of each pair, from M down to I.
    function automatic logic [NUM_W-1:0] pair_value(input logic [IDX_W-1:0] idx);
        logic [NUM_W-1:0] v;
        case (idx)
            4'd0:    v = 12'd1000;
            4'd1:    v = 12'd900;
            4'd2:    v = 12'd500;
            4'd3:    v = 12'd400;
            4'd4:    v = 12'd100;
            4'd5:    v = 12'd90;
            4'd6:    v = 12'd50;
            4'd7:    v = 12'd40;
            4'd8:    v = 12'd10;
            4'd9:    v = 12'd9;
            4'd10:   v = 12'd5;
            4'd11:   v = 12'd4;
            4'd12:   v = 12'd1;
            default: v = 12'd1;
        endcase
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] pair_first(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            4'd0:    c = CHAR_M;
            4'd1:    c = CHAR_C;
            4'd2:    c = CHAR_D;
            4'd3:    c = CHAR_C;
            4'd4:    c = CHAR_C;
            4'd5:    c = CHAR_X;
            4'd6:    c = CHAR_L;
            4'd7:    c = CHAR_X;
            4'd8:    c = CHAR_X;
            4'd9:    c = CHAR_I;
            4'd10:   c = CHAR_V;
            4'd11:   c = CHAR_I;
            4'd12:   c = CHAR_I;
            default: c = CHAR_I;
        endcase
        return c;
    endfunction

    // Second letter of a subtractive pair; CHAR_NONE for a single letter.
    function automatic logic [CHAR_W-1:0] pair_second(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            4'd1:    c = CHAR_M;
            4'd3:    c = CHAR_D;
            4'd5:    c = CHAR_C;
            4'd7:    c = CHAR_L;
            4'd9:    c = CHAR_X;
            4'd11:   c = CHAR_V;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/irn_if.sv -----
interface irn_num_if;
    logic                      valid;
    logic                      ready;
    logic [irn_pkg::NUM_W-1:0] number_in;

    modport source (output valid, output number_in, input ready);
    modport sink   (input valid, input number_in, output ready);
endinterface

interface irn_sym_if;
    logic                       valid;
    logic                       ready;
    logic [irn_pkg::CHAR_W-1:0] symbol_char;
    logic                       last_char;

    modport source (output valid, output symbol_char, output last_char, input ready);
    modport sink   (input valid, input symbol_char, input last_char, output ready);
endinterface

// ----- rtl/core/integer_to_roman_numeral_core.sv -----
// A number is queued, then loaded by the greedy sequencer; each letter it emits is
// held in the output register. Throughput: one letter per cycle while the output is
// not stalled; the sequencer emits nothing while it skips a pair or loads a number.
// A two-entry queue lets up to two numbers be accepted while a run is being emitted.
// Reset is synchronous and active low; it empties the queue and the output register.
module integer_to_roman_numeral_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    irn_num_if.sink   i_num,
    irn_sym_if.source o_sym
);
    import irn_pkg::*;

    t_job job;
    logic pop;

    // Front part: accept, saturate and queue numbers.
    irn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (i_num),
        .o_job   (job),
        .i_pop   (pop)
    );

    // Back part: emit the letters of one number at a time.
    irn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job),
        .o_pop   (pop),
        .o_sym   (o_sym)
    );

endmodule

// ----- rtl/core/irn_front.sv -----
module irn_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    irn_num_if.sink       i_num,
    output irn_pkg::t_job o_job,
    input  logic          i_pop
);
    import irn_pkg::*;

    logic [NUM_W-1:0]  r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic [NUM_W-1:0]  sat_value;
    logic              accept;
    logic              push;
    logic              pop;

    // Saturate the beat; a zero yields no letters and is dropped here.
    assign sat_value = (i_num.number_in > VALUE_MAX) ? VALUE_MAX : i_num.number_in;
    assign i_num.ready = (r_count < QCNT_W'(QUEUE_DEPTH));
    assign accept = i_num.valid && i_num.ready;
    assign push   = accept && (i_num.number_in != '0);
    assign pop    = i_pop && (r_count != '0);

    assign o_job.valid = (r_count != '0);
    assign o_job.value = r_queue[r_rd_ptr];

    // Queue pointers and fill count.
    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= sat_value;
        end
    end

endmodule

// ----- rtl/core/irn_back.sv -----
module irn_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  irn_pkg::t_job i_job,
    output logic          o_pop,
    irn_sym_if.source     o_sym
);
    import irn_pkg::*;

    logic [NUM_W-1:0]  r_rem, n_rem;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_second, n_second;
    logic              r_busy, n_busy;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic              r_out_last, n_out_last;

    logic [NUM_W-1:0]  cur_value;
    logic [NUM_W-1:0]  diff;
    logic [CHAR_W-1:0] second_char;
    logic              has_second;
    logic              can_emit;

    assign cur_value   = pair_value(r_idx);
    assign diff        = r_rem - cur_value;
    assign second_char = pair_second(r_idx);
    assign has_second  = (second_char != CHAR_NONE);
    assign can_emit    = !r_out_valid || o_sym.ready;

    // Greedy sequencer: one letter or one pair advance per cycle; a letter waits while the output beat is stalled.
    always_comb begin
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_second    = r_second;
        n_busy      = r_busy;
        n_out_valid = r_out_valid && !o_sym.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        if (r_busy) begin
            if (r_second) begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_char  = second_char;
                    n_out_last  = (r_rem == '0);
                    n_second    = 1'b0;
                    n_busy      = (r_rem != '0);
                end
            end else if (r_rem >= cur_value) begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_char  = pair_first(r_idx);
                    n_out_last  = (diff == '0) && !has_second;
                    n_rem       = diff;
                    n_second    = has_second;
                    n_busy      = (diff != '0) || has_second;
                end
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end else if (i_job.valid) begin
            o_pop    = 1'b1;
            n_rem    = i_job.value;
            n_idx    = '0;
            n_second = 1'b0;
            n_busy   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_idx       <= '0;
            r_second    <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rem       <= n_rem;
            r_idx       <= n_idx;
            r_second    <= n_second;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_sym.valid       = r_out_valid;
    assign o_sym.symbol_char = r_out_char;
    assign o_sym.last_char   = r_out_last;

endmodule

// ----- rtl/core/irn_checker.sv -----
module irn_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [irn_pkg::CHAR_W-1:0] i_symbol_char,
    input logic                      i_last_char
);
    import irn_pkg::*;

    // A stalled beat holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_symbol_char) && $stable(i_last_char))
        else $error("output beat changed while stalled");

    // Every beat carries a Roman letter.
    a_legal_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_symbol_char == CHAR_I || i_symbol_char == CHAR_V ||
                         i_symbol_char == CHAR_X || i_symbol_char == CHAR_L ||
                         i_symbol_char == CHAR_C || i_symbol_char == CHAR_D ||
                         i_symbol_char == CHAR_M))
        else $error("output beat is not a Roman letter");

    // Reset empties the output register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind integer_to_roman_numeral_core irn_checker u_irn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_sym.valid),
    .i_out_ready   (o_sym.ready),
    .i_symbol_char (o_sym.symbol_char),
    .i_last_char   (o_sym.last_char)
);
